### design/sset_pkg.sv
// shared constants, command and status types for the sorted set block
// no dependencies

package sset_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_BITS  = 16;
    localparam int FIELD_BITS  = 16;
    localparam int OUT_CNT_W   = 7;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    typedef struct packed {
        logic accept;
        logic rd_mid;
        logic cmp;
        logic sh_rd;
        logic sh_wr;
        logic wr_val;
        logic load_out;
    } sset_cmd_t;

    typedef struct packed {
        logic search_done;
        logic k_at_pos;
        logic do_insert;
        logic out_busy;
    } sset_sts_t;

endpackage

### design/sset_if.sv
// request and response channel interfaces
// depends on sset_pkg

interface sset_req_if
    import sset_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [FIELD_BITS-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sset_rsp_if
    import sset_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic                 inserted;
    logic                 overflow;
    logic [OUT_CNT_W-1:0] entry_count;

    modport source (output valid, output found, output inserted, output overflow,
                    output entry_count, input ready);
    modport sink   (input valid, input found, input inserted, input overflow,
                    input entry_count, output ready);
endinterface

### design/sset_ram.sv
// generic single write port ram with registered read
// no dependencies

module sset_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/sset_ctrl.sv
// controller: sequences search, shift, insert and result hand-off
// depends on sset_pkg

module sset_ctrl
    import sset_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  sset_sts_t sts,
    output sset_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_SHRD = 3'd4;
    localparam logic [2:0] S_SHWR = 3'd5;
    localparam logic [2:0] S_WRV  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.search_done)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_RD;
            end
            S_CHK:
            begin
                state_next = sts.do_insert ? S_SHRD : S_FIN;
            end
            S_SHRD:
            begin
                if (sts.k_at_pos)
                begin
                    state_next = S_WRV;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SHRD;
            end
            S_WRV:
            begin
                cmd.wr_val = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### design/sset_dp.sv
// datapath: entry store, search bounds, shift pointer, count and result register
// depends on sset_pkg, sset_if, sset_ram

module sset_dp
    import sset_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_type,
    input  logic [FIELD_BITS-1:0] value,
    input  sset_cmd_t             cmd,
    output sset_sts_t             sts,
    sset_rsp_if.source            rsp
);

    cnt_t   count_reg, count_next;
    cnt_t   lo_reg, lo_next;
    cnt_t   hi_reg, hi_next;
    cnt_t   k_reg, k_next;
    value_t v_reg, v_next;
    logic   ins_reg, ins_next;
    logic   found_reg, found_next;
    logic   added_reg, added_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic                 out_ins_reg, out_ins_next;
    logic                 out_over_reg, out_over_next;
    logic [OUT_CNT_W-1:0] out_cnt_reg, out_cnt_next;

    logic [CNT_W:0] mid_sum;
    cnt_t           mid;
    cnt_t           k_dec;
    logic           full;
    logic           we;
    addr_t          waddr;
    addr_t          raddr;
    value_t         wdata;
    value_t         rdata;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign k_dec   = k_reg - cnt_t'(1);
    assign full    = (count_reg == cnt_t'(DEPTH));

    assign sts.search_done = (lo_reg == hi_reg);
    assign sts.k_at_pos    = (k_reg == lo_reg);
    assign sts.do_insert   = ins_reg && !found_reg && !full;
    assign sts.out_busy    = out_valid_reg && !rsp.ready;

    always_comb
    begin
        raddr = mid[ADDR_W-1:0];
        if (cmd.sh_rd)
        begin
            raddr = k_dec[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        we    = cmd.sh_wr || cmd.wr_val;
        waddr = cmd.wr_val ? lo_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
        wdata = cmd.wr_val ? v_reg : rdata;
    end

    sset_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        v_next     = v_reg;
        ins_next   = ins_reg;
        found_next = found_reg;
        added_next = added_reg;
        if (cmd.accept)
        begin
            lo_next    = '0;
            hi_next    = count_reg;
            k_next     = count_reg;
            v_next     = value[VALUE_BITS-1:0];
            ins_next   = req_type;
            found_next = 1'b0;
            added_next = 1'b0;
        end
        if (cmd.cmp)
        begin
            if (rdata < v_reg)
            begin
                lo_next = mid + cnt_t'(1);
            end
            else
            begin
                hi_next = mid;
            end
            if (rdata == v_reg)
            begin
                found_next = 1'b1;
            end
        end
        if (cmd.sh_wr)
        begin
            k_next = k_dec;
        end
        if (cmd.wr_val)
        begin
            count_next = count_reg + cnt_t'(1);
            added_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_ins_next   = out_ins_reg;
        out_over_next  = out_over_reg;
        out_cnt_next   = out_cnt_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_found_next = found_reg;
            out_ins_next   = added_reg;
            out_over_next  = ins_reg && !found_reg && !added_reg && full;
            out_cnt_next   = OUT_CNT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        k_reg         <= k_next;
        v_reg         <= v_next;
        ins_reg       <= ins_next;
        found_reg     <= found_next;
        added_reg     <= added_next;
        out_found_reg <= out_found_next;
        out_ins_reg   <= out_ins_next;
        out_over_reg  <= out_over_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.inserted    = out_ins_reg;
    assign rsp.overflow    = out_over_reg;
    assign rsp.entry_count = out_cnt_reg;

endmodule

### design/sorted_set_insert_lookup.sv
// top level of the sorted set with insert and membership query
// depends on sset_pkg, sset_if, sset_ctrl, sset_dp
//
// channel  dir  fields                                   transfer when
// req      in   req_type, value                          req.valid && req.ready
// rsp      out  found, inserted, overflow, entry_count   rsp.valid && rsp.ready
//
// one item at a time; a query runs a binary search over the n held entries,
// about ceil(log2(n + 1)) steps, each a read of the ram and then a compare
// an insert of a new value then moves the entries from position pos up by one
// and writes the value at pos; each shift step reads over the ram's registered read
// no clearing pass after reset: the count alone marks which entries are held
// a stalled result waits in its register while the next request is worked on

module sorted_set_insert_lookup
    import sset_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sset_req_if.sink   req,
    sset_rsp_if.source rsp
);

    sset_cmd_t cmd;
    sset_sts_t sts;
    logic      ready;

    assign req.ready = ready;

    sset_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req.valid),
        .req_ready(ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sset_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_type(req.req_type),
        .value   (req.value),
        .cmd     (cmd),
        .sts     (sts),
        .rsp     (rsp)
    );

endmodule

### design/sset_checker.sv
// port-level checks of the sorted set top level, attached by bind
// depends on sset_pkg and sorted_set_insert_lookup

module sset_checker
    import sset_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic                 found,
    input logic                 inserted,
    input logic                 overflow,
    input logic [OUT_CNT_W-1:0] entry_count
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(found) && $stable(inserted)
            && $stable(overflow) && $stable(entry_count))
        else $error("response payload changed while stalled");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $countones({found, inserted, overflow}) <= 1)
        else $error("conflicting result flags");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (inserted || overflow) |-> entry_count != '0)
        else $error("insert outcome with empty store");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in progress");

endmodule

bind sorted_set_insert_lookup sset_checker u_sset_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .found      (rsp.found),
    .inserted   (rsp.inserted),
    .overflow   (rsp.overflow),
    .entry_count(rsp.entry_count)
);
